// ===== rtl/salc_pkg.sv =====
package salc_pkg;

  // cache geometry
  localparam int LINE_SIZE  = 64;
  localparam int NUM_SETS   = 32;
  localparam int NUM_WAYS   = 4;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;

  // derived widths
  localparam int OFF_W = $clog2(LINE_SIZE);
  localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int TAG_W = ADDR_W - OFF_W - ((NUM_SETS > 1) ? $clog2(NUM_SETS) : 0);
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int AGE_W = WAY_W;

  // one set: tag and age rank (0 = most recently used) per way
  typedef struct packed {
    logic [NUM_WAYS-1:0][TAG_W-1:0] tags;
    logic [NUM_WAYS-1:0][AGE_W-1:0] ages;
  } row_t;

  // controller states
  typedef enum logic [0:0] {
    S_IDLE,
    S_LOOKUP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/set_assoc_lru_cache_miss_counter.sv =====
// channel | signals                          | direction | word
// in      | in_valid, in_ready, byte_address | in        | one byte address
// out     | out_valid, out_ready, hit,       | out       | one lookup result
//         | evicted, miss_total              |           |
//
// For each address the set row is read from the set memory at capture,
// then tags are compared, LRU ranks updated and the row written back.
// The result sits in an output register; a new address is taken while it waits,
// and the write-back stalls only if the previous result is still not taken.
// Reset clears state, valid flags and the miss counter at once; no sweep.
module set_assoc_lru_cache_miss_counter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [salc_pkg::ADDR_W-1:0] byte_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic                        evicted,
  output logic [salc_pkg::CNT_W-1:0]  miss_total
);
  import salc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // tag store, lru ranks and counter
  salc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .byte_address (byte_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .evicted      (evicted),
    .miss_total   (miss_total)
  );

endmodule

// ===== rtl/salc_ctrl.sv =====
module salc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  salc_pkg::status_t status,
  output salc_pkg::cmd_t    cmd
);
  import salc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // wait for the result register to free up
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/salc_dp.sv =====
module salc_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  salc_pkg::cmd_t              cmd,
  output salc_pkg::status_t           status,
  input  logic [salc_pkg::ADDR_W-1:0] byte_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic                        evicted,
  output logic [salc_pkg::CNT_W-1:0]  miss_total
);
  import salc_pkg::*;

  // set storage and valid flags
  row_t                mem [NUM_SETS];
  logic [NUM_WAYS-1:0] valid_q [NUM_SETS];

  // captured word
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  row_t             rd_row;
  logic [SET_W-1:0] set_in;

  // result registers
  logic             out_valid_q;
  logic             hit_q;
  logic             evicted_q;
  logic [CNT_W-1:0] miss_cnt;

  // lookup results
  logic [NUM_WAYS-1:0] way_valid;
  logic                hit_any;
  logic [WAY_W-1:0]    hit_way;
  logic                empty_any;
  logic [WAY_W-1:0]    empty_way;
  logic                vic_found;
  logic [WAY_W-1:0]    vic_way;
  logic [AGE_W-1:0]    vic_age;
  logic [WAY_W-1:0]    tgt_way;
  logic [AGE_W:0]      old_age;
  row_t                new_row;

  if (NUM_SETS > 1) begin : g_set
    assign set_in = byte_address[OFF_W +: SET_W];
  end else begin : g_noset
    assign set_in = '0;
  end

  // capture address fields and read the set row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q  <= set_in;
      tag_q  <= byte_address[ADDR_W-1 -: TAG_W];
      rd_row <= mem[set_in];
    end
  end

  // write back the updated row
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem[set_q] <= new_row;
    end
  end

  // valid flags, cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (cmd.commit && !hit_any) begin
      valid_q[set_q][tgt_way] <= 1'b1;
    end
  end

  assign way_valid = valid_q[set_q];

  // tag compare, first empty way and oldest valid way
  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    vic_found = 1'b0;
    vic_way   = '0;
    vic_age   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (way_valid[w] && (rd_row.tags[w] == tag_q) && !hit_any) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!way_valid[w]) begin
        if (!empty_any) begin
          empty_any = 1'b1;
          empty_way = WAY_W'(w);
        end
      end else if (!vic_found || (rd_row.ages[w] > vic_age)) begin
        vic_found = 1'b1;
        vic_age   = rd_row.ages[w];
        vic_way   = WAY_W'(w);
      end
    end
  end

  // pick the way to promote and its previous rank
  always_comb begin
    if (hit_any) begin
      tgt_way = hit_way;
      old_age = {1'b0, rd_row.ages[hit_way]};
    end else if (empty_any) begin
      tgt_way = empty_way;
      old_age = (AGE_W + 1)'(NUM_WAYS);
    end else begin
      tgt_way = vic_way;
      old_age = {1'b0, vic_age};
    end
  end

  // age the younger lines, make the target most recent, write the tag on a miss
  always_comb begin
    new_row = rd_row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == tgt_way) begin
        new_row.ages[w] = '0;
      end else if (way_valid[w] && ({1'b0, rd_row.ages[w]} < old_age)) begin
        new_row.ages[w] = rd_row.ages[w] + AGE_W'(1);
      end
    end
    if (!hit_any) begin
      new_row.tags[tgt_way] = tag_q;
    end
  end

  // result word and saturating miss counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
      miss_cnt    <= '0;
    end else begin
      if (cmd.commit) begin
        out_valid_q <= 1'b1;
        if (!hit_any && (miss_cnt != {CNT_W{1'b1}})) begin
          miss_cnt <= miss_cnt + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_q     <= hit_any;
      evicted_q <= !hit_any && !empty_any;
    end
  end

  assign status.out_busy = out_valid_q && !out_ready;
  assign out_valid       = out_valid_q;
  assign hit             = hit_q;
  assign evicted         = evicted_q;
  assign miss_total      = miss_cnt;

endmodule

// ===== rtl/salc_checker.sv =====
module salc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        hit,
  input logic                        evicted,
  input logic [salc_pkg::CNT_W-1:0]  miss_total
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(evicted)
      && $stable(miss_total))
    else $error("result word changed while stalled");

  // an eviction only happens on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit and evicted both set");

  // one address in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("address taken while lookup busy");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready && (miss_total == '0))
    else $error("bad state after reset");

endmodule

bind set_assoc_lru_cache_miss_counter salc_checker u_chk (.*);

// ===== tb/sv/tb.sv =====
module tb;
  import salc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE = 277;

  // one expected lookup outcome
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [CNT_W-1:0] misses;
  } lookup_t;

  // tag-state predictor and store of outstanding lookups
  class cache_lookup_sb;
    logic [TAG_W-1:0] tag_mem   [NUM_SETS][NUM_WAYS];
    bit               valid_mem [NUM_SETS][NUM_WAYS];
    int unsigned      age_mem   [NUM_SETS][NUM_WAYS];
    logic [CNT_W-1:0] misses;
    lookup_t          expected_lookups[$];
    int unsigned      fails;

    function new();
      foreach (valid_mem[s, w]) begin
        valid_mem[s][w] = 1'b0;
        age_mem[s][w] = 0;
        tag_mem[s][w] = '0;
      end
      misses = '0;
      fails = 0;
    endfunction

    // make way w the most recent; younger valid ways age by one
    function void make_recent(int s, int w, int unsigned old_age);
      for (int k = 0; k < NUM_WAYS; k++) begin
        if (k != w && valid_mem[s][k] && age_mem[s][k] < old_age) age_mem[s][k]++;
      end
      age_mem[s][w] = 0;
    endfunction

    // work out the outcome of one accepted address and queue it
    function void note_address(logic [ADDR_W-1:0] a);
      logic [ADDR_W-OFF_W-1:0] line;
      logic [TAG_W-1:0] t;
      int s;
      int empty_way;
      int victim;
      int unsigned oldest;
      bit found;
      lookup_t r;
      line = a[ADDR_W-1:OFF_W];
      s = int'(line % NUM_SETS);
      t = TAG_W'(line / NUM_SETS);
      r = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (valid_mem[s][w] && tag_mem[s][w] == t) begin
          make_recent(s, w, age_mem[s][w]);
          r.hit = 1'b1;
          break;
        end
      end
      if (!r.hit) begin
        if (misses != '1) misses++;
        empty_way = -1;
        victim = 0;
        oldest = 0;
        found = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (!valid_mem[s][w]) begin
            if (empty_way < 0) empty_way = w;
          end else if (!found || age_mem[s][w] > oldest) begin
            oldest = age_mem[s][w];
            victim = w;
            found = 1'b1;
          end
        end
        if (empty_way >= 0) begin
          // fill the lowest free way, every valid line grows older
          tag_mem[s][empty_way] = t;
          valid_mem[s][empty_way] = 1'b1;
          age_mem[s][empty_way] = NUM_WAYS;
          make_recent(s, empty_way, NUM_WAYS);
        end else begin
          tag_mem[s][victim] = t;
          make_recent(s, victim, age_mem[s][victim]);
          r.evicted = 1'b1;
        end
      end
      r.misses = misses;
      expected_lookups.push_back(r);
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic h, logic e, logic [CNT_W-1:0] m);
      lookup_t x;
      if (expected_lookups.size() == 0) begin
        $error("result with nothing expected: hit %0d evicted %0d miss_total %0d", h, e, m);
        fails++;
        return;
      end
      x = expected_lookups.pop_front();
      if (h !== x.hit) begin
        $error("hit: expected %0d, actual %0d", x.hit, h);
        fails++;
      end
      if (e !== x.evicted) begin
        $error("evicted: expected %0d, actual %0d", x.evicted, e);
        fails++;
      end
      if (m !== x.misses) begin
        $error("miss_total: expected %0d, actual %0d", x.misses, m);
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] byte_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic              evicted;
  logic [CNT_W-1:0]  miss_total;

  cache_lookup_sb sb = new();
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 66;
  bit          hold_go = 1'b0;
  int unsigned cycle_count = 0;

  set_assoc_lru_cache_miss_counter i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_address (byte_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .evicted      (evicted),
    .miss_total   (miss_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(hit, evicted, miss_total);
      if (hold_go && !held) begin
        hold_left = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] make_address(logic [TAG_W-1:0] t, int s, int off);
    logic [SET_W-1:0] sb_set;
    logic [OFF_W-1:0] sb_off;
    sb_set = SET_W'(s);
    sb_off = OFF_W'(off);
    return {t, sb_set, sb_off};
  endfunction

  // offer one address word, with an optional gap before it
  task automatic send_address(logic [ADDR_W-1:0] a);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    byte_address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_address(a);
  endtask

  // mostly a few hot sets and a small tag pool, so hits and evictions are common
  task automatic run_random(int unsigned n);
    logic [TAG_W-1:0] pool[6];
    int hot[3];
    foreach (pool[i]) pool[i] = TAG_W'($urandom);
    foreach (hot[i]) hot[i] = $urandom_range(0, NUM_SETS - 1);
    repeat (n) begin
      if ($urandom_range(0, 99) < 75)
        send_address(make_address(pool[$urandom_range(0, 5)], hot[$urandom_range(0, 2)],
                                  $urandom_range(0, LINE_SIZE - 1)));
      else
        send_address($urandom);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, same line, fill of one set, hits and LRU evictions
    send_address('0);
    send_address('1);
    send_address(ADDR_W'(LINE_SIZE - 1));
    send_address(make_address(1, 3, 0));
    send_address(make_address(2, 3, 4));
    send_address(make_address(3, 3, 8));
    send_address(make_address(4, 3, LINE_SIZE - 1));
    send_address(make_address(1, 3, 1));
    send_address(make_address(5, 3, 0));
    send_address(make_address(3, 3, 0));
    send_address(make_address(2, 3, 0));
    send_address(make_address(2, 3, 0));
    send_address(make_address(5, 3, 0));
    send_address(make_address(1, 3, 0));
    send_address(make_address(4, 3, 0));
    send_address(make_address(4, 3, 0));
    send_address(make_address('1, 0, 0));
    send_address(make_address('0, NUM_SETS - 1, LINE_SIZE - 1));
    send_address(make_address(6, 3, 2));
    send_address(make_address(3, 3, 3));

    run_random(ITEMS_PER_PHASE);

    send_idle_pct = 66;
    recv_idle_pct = 37;
    run_random(ITEMS_PER_PHASE);

    // no idling; the receiver holds off for a while to fill the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    run_random(ITEMS_PER_PHASE);
    in_valid <= 1'b0;

    while (sb.expected_lookups.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/salc_pkg.sv
rtl/salc_ctrl.sv
rtl/salc_dp.sv
rtl/set_assoc_lru_cache_miss_counter.sv
rtl/salc_checker.sv
tb/sv/tb.sv
